@@ rtl/core/rcsfr_pkg.sv @@
// rcsfr_pkg: shared constants, types and the crc-8 step of the rc serial frame receiver
// no dependencies; used by every file of the block by scoped names

package rcsfr_pkg;

   // defaults of the top level parameters
   localparam int DEF_MAX_FRAME_BYTES = 64;
   localparam int DEF_CHANNEL_COUNT   = 12;

   // field widths
   localparam int BYTE_W      = 8;
   localparam int TIME_W      = 32;
   localparam int CH_INDEX_W  = 4;
   localparam int CH_VALUE_W  = 11;
   localparam int FULL_W      = 9;

   // framing constants
   localparam int POS_ADDR      = 0;
   localparam int POS_LEN       = 1;
   localparam int POS_TYPE      = 2;
   localparam int PAYLOAD_START = 3;
   localparam int ASSUMED_LEN   = 5;
   localparam int LEN_OVERHEAD  = 2;
   localparam int CH_BITS       = 11;
   localparam int CH_SPAN_BYTES = 3;
   localparam logic [7:0] CRC_TOP_BIT = 8'h80;

   // configuration port
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int REG_ADDR_LSB = 2;

   localparam logic [15:0] RST_FRAME_TIMEOUT = 16'd1100;
   localparam logic [7:0]  RST_RX_ADDRESS    = 8'd200;
   localparam logic [7:0]  RST_FULL_TYPE     = 8'd22;
   localparam logic [7:0]  RST_SUBSET_TYPE   = 8'd23;
   localparam logic [7:0]  RST_CRC_POLY      = 8'd213;

   typedef enum logic [CSR_ADDR_W-REG_ADDR_LSB-1:0] {
      REG_FRAME_TIMEOUT = 3'd0,
      REG_RX_ADDRESS    = 3'd1,
      REG_FULL_TYPE     = 3'd2,
      REG_SUBSET_TYPE   = 3'd3,
      REG_CRC_POLY      = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [15:0] frame_timeout_us;
      logic [7:0]  receiver_address;
      logic [7:0]  full_channels_type;
      logic [7:0]  subset_channels_type;
      logic [7:0]  crc_polynomial;
   } cfg_type;

   // width of a buffer read address that covers the buffer and every channel byte
   function automatic int read_addr_width(input int max_bytes, input int chans);
      return $clog2(max_bytes + PAYLOAD_START + ((chans * CH_BITS) >> 3) + CH_SPAN_BYTES);
   endfunction

   // one byte of an msb-first crc-8
   function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                              input logic [7:0] data,
                                              input logic [7:0] poly);
      logic [7:0] c;
      c = crc_in ^ data;
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP_BIT) != 8'd0) begin
            c = (c << 1) ^ poly;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

@@ rtl/core/rcsfr_req_if.sv @@
// rcsfr_req_if: valid/ready channel of received serial bytes with arrival times
// depends on rcsfr_pkg for field widths

interface rcsfr_req_if;
   logic                            valid;
   logic                            ready;
   logic [rcsfr_pkg::BYTE_W-1:0]    byte_value;
   logic [rcsfr_pkg::TIME_W-1:0]    arrival_time_us;

   modport source (output valid, byte_value, arrival_time_us, input ready);
   modport sink   (input valid, byte_value, arrival_time_us, output ready);
endinterface

@@ rtl/core/rcsfr_rsp_if.sv @@
// rcsfr_rsp_if: valid/ready channel of decoded rc channel values
// depends on rcsfr_pkg for field widths

interface rcsfr_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [rcsfr_pkg::CH_INDEX_W-1:0]   channel_index;
   logic [rcsfr_pkg::CH_VALUE_W-1:0]   channel_value;
   logic                               last_channel;

   modport source (output valid, channel_index, channel_value, last_channel, input ready);
   modport sink   (input valid, channel_index, channel_value, last_channel, output ready);
endinterface

@@ rtl/core/rcsfr_ram.sv @@
// rcsfr_ram: generic single-port-write, single-port-read ram with registered read data
// depends on rcsfr_pkg for parameter defaults

module rcsfr_ram #(
   parameter int WIDTH = rcsfr_pkg::BYTE_W,
   parameter int DEPTH = rcsfr_pkg::DEF_MAX_FRAME_BYTES,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/rcsfr_buffer.sv @@
// rcsfr_buffer: frame byte store, a ram with a valid bit per entry and range masking
// depends on rcsfr_pkg and rcsfr_ram

module rcsfr_buffer #(
   parameter int MAX_FRAME_BYTES = rcsfr_pkg::DEF_MAX_FRAME_BYTES,
   parameter int RA_W = rcsfr_pkg::read_addr_width(rcsfr_pkg::DEF_MAX_FRAME_BYTES,
                                                    rcsfr_pkg::DEF_CHANNEL_COUNT),
   localparam int AW = $clog2(MAX_FRAME_BYTES)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [rcsfr_pkg::BYTE_W-1:0]  wr_data,
   input  logic                          rd_en,
   input  logic [RA_W-1:0]               rd_addr,
   output logic [rcsfr_pkg::BYTE_W-1:0]  rd_data
);

   logic [MAX_FRAME_BYTES-1:0]     valid_ff;
   logic                           rd_ok_ff;
   logic                           rd_ok_in;
   logic [rcsfr_pkg::BYTE_W-1:0]   ram_q;

   rcsfr_ram #(
      .WIDTH (rcsfr_pkg::BYTE_W),
      .DEPTH (MAX_FRAME_BYTES)
   ) u_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (wr_data),
      .re    (rd_en),
      .raddr (rd_addr[AW-1:0]),
      .rdata (ram_q)
   );

   // an entry reads as zero until written, and beyond the buffer always
   assign rd_ok_in = (rd_addr < RA_W'(MAX_FRAME_BYTES)) && valid_ff[rd_addr[AW-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_ok_ff <= rd_ok_in;
         end
      end
   end

   assign rd_data = rd_ok_ff ? ram_q : '0;

endmodule

@@ rtl/core/rcsfr_csr.sv @@
// rcsfr_csr: apb-style configuration registers of the rc serial frame receiver
// depends on rcsfr_pkg for the register map and reset values

module rcsfr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rcsfr_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [rcsfr_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [rcsfr_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                              pready,
   output rcsfr_pkg::cfg_type                cfg
);

   rcsfr_pkg::cfg_type        cfg_ff;
   rcsfr_pkg::reg_index_type  reg_index;
   logic                      wr_transfer;

   assign pready      = 1'b1;
   assign wr_transfer = psel && penable && pwrite;
   assign reg_index   = rcsfr_pkg::reg_index_type'(
                           paddr[rcsfr_pkg::CSR_ADDR_W-1:rcsfr_pkg::REG_ADDR_LSB]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_timeout_us     <= rcsfr_pkg::RST_FRAME_TIMEOUT;
         cfg_ff.receiver_address     <= rcsfr_pkg::RST_RX_ADDRESS;
         cfg_ff.full_channels_type   <= rcsfr_pkg::RST_FULL_TYPE;
         cfg_ff.subset_channels_type <= rcsfr_pkg::RST_SUBSET_TYPE;
         cfg_ff.crc_polynomial       <= rcsfr_pkg::RST_CRC_POLY;
      end else if (wr_transfer) begin
         unique case (reg_index)
            rcsfr_pkg::REG_FRAME_TIMEOUT: cfg_ff.frame_timeout_us     <= pwdata[15:0];
            rcsfr_pkg::REG_RX_ADDRESS:    cfg_ff.receiver_address     <= pwdata[7:0];
            rcsfr_pkg::REG_FULL_TYPE:     cfg_ff.full_channels_type   <= pwdata[7:0];
            rcsfr_pkg::REG_SUBSET_TYPE:   cfg_ff.subset_channels_type <= pwdata[7:0];
            rcsfr_pkg::REG_CRC_POLY:      cfg_ff.crc_polynomial       <= pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_index)
         rcsfr_pkg::REG_FRAME_TIMEOUT: prdata = {16'd0, cfg_ff.frame_timeout_us};
         rcsfr_pkg::REG_RX_ADDRESS:    prdata = {24'd0, cfg_ff.receiver_address};
         rcsfr_pkg::REG_FULL_TYPE:     prdata = {24'd0, cfg_ff.full_channels_type};
         rcsfr_pkg::REG_SUBSET_TYPE:   prdata = {24'd0, cfg_ff.subset_channels_type};
         rcsfr_pkg::REG_CRC_POLY:      prdata = {24'd0, cfg_ff.crc_polynomial};
         default:                      prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/rcsfr_sequencer.sv @@
// rcsfr_sequencer: framing control, crc pass over the buffer and channel unpacking
// depends on rcsfr_pkg, rcsfr_req_if and rcsfr_rsp_if; drives the frame buffer ports

module rcsfr_sequencer #(
   parameter int MAX_FRAME_BYTES = rcsfr_pkg::DEF_MAX_FRAME_BYTES,
   parameter int CHANNEL_COUNT   = rcsfr_pkg::DEF_CHANNEL_COUNT,
   parameter int RA_W = rcsfr_pkg::read_addr_width(rcsfr_pkg::DEF_MAX_FRAME_BYTES,
                                                    rcsfr_pkg::DEF_CHANNEL_COUNT),
   localparam int AW = $clog2(MAX_FRAME_BYTES)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rcsfr_pkg::cfg_type            cfg,
   rcsfr_req_if.sink                     req,
   rcsfr_rsp_if.source                   rsp,
   output logic                          buf_wr_en,
   output logic [AW-1:0]                 buf_wr_addr,
   output logic [rcsfr_pkg::BYTE_W-1:0]  buf_wr_data,
   output logic                          buf_rd_en,
   output logic [RA_W-1:0]               buf_rd_addr,
   input  logic [rcsfr_pkg::BYTE_W-1:0]  buf_rd_data
);

   localparam int POS_W  = $clog2(MAX_FRAME_BYTES + 1);
   localparam int FULL_W = rcsfr_pkg::FULL_W;
   localparam int CMP_W  = (POS_W > FULL_W) ? POS_W : FULL_W;
   localparam int BP_W   = $clog2(CHANNEL_COUNT * rcsfr_pkg::CH_BITS + 1);
   localparam int IDX_W  = rcsfr_pkg::CH_INDEX_W;
   localparam int VAL_W  = rcsfr_pkg::CH_VALUE_W;
   localparam int ASM_W  = rcsfr_pkg::CH_SPAN_BYTES * rcsfr_pkg::BYTE_W;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_CRC_RD  = 8'b0000_0010,
      ST_CRC_END = 8'b0000_0100,
      ST_CH_RD0  = 8'b0000_1000,
      ST_CH_RD1  = 8'b0001_0000,
      ST_CH_RD2  = 8'b0010_0000,
      ST_CH_CAP  = 8'b0100_0000,
      ST_CH_EMIT = 8'b1000_0000
   } state_type;

   state_type                      state_ff;
   logic [POS_W-1:0]               pos_ff;
   logic [rcsfr_pkg::TIME_W-1:0]   start_ff;
   logic [7:0]                     addr_byte_ff;
   logic [7:0]                     len_byte_ff;
   logic [7:0]                     type_byte_ff;
   logic [AW-1:0]                  last_idx_ff;
   logic [AW-1:0]                  rd_addr_ff;
   logic [7:0]                     crc_rx_ff;
   logic [7:0]                     crc_acc_ff;
   logic [7:0]                     poly_ff;
   logic                           rc_ok_ff;
   logic                           rdv_ff;
   logic [ASM_W-1:0]               asm_ff;
   logic [IDX_W-1:0]               ch_ff;
   logic [BP_W-1:0]                bitpos_ff;
   logic                           rsp_valid_ff;
   logic [IDX_W-1:0]               rsp_index_ff;
   logic [VAL_W-1:0]               rsp_value_ff;
   logic                           rsp_last_ff;

   logic                           accept;
   logic [rcsfr_pkg::TIME_W-1:0]   gap;
   logic                           restart;
   logic [POS_W-1:0]               pos_eff;
   logic [POS_W-1:0]               pos_new;
   logic [FULL_W-1:0]              full;
   logic                           skip;
   logic                           done;
   logic                           rc_frame;
   logic [7:0]                     crc_next;
   logic [RA_W-1:0]                chan_base;
   logic [ASM_W-1:0]               asm_shifted;
   logic                           ch_last;
   logic                           out_free;

   // per-byte framing decision
   assign accept  = req.valid && req.ready;
   assign gap     = req.arrival_time_us - start_ff;
   assign restart = !gap[rcsfr_pkg::TIME_W-1] &&
                    (gap > {16'd0, cfg.frame_timeout_us});
   assign pos_eff = restart ? '0 : pos_ff;
   assign pos_new = pos_eff + POS_W'(1);
   assign full    = (pos_eff < POS_W'(rcsfr_pkg::PAYLOAD_START)) ?
                    FULL_W'(rcsfr_pkg::ASSUMED_LEN) :
                    {1'b0, len_byte_ff} + FULL_W'(rcsfr_pkg::LEN_OVERHEAD);
   assign skip    = (CMP_W'(full) > CMP_W'(MAX_FRAME_BYTES)) ||
                    (CMP_W'(pos_eff) >= CMP_W'(full));
   assign done    = !skip && (CMP_W'(pos_new) == CMP_W'(full));
   assign rc_frame = ((type_byte_ff == cfg.full_channels_type) ||
                      (type_byte_ff == cfg.subset_channels_type)) &&
                     (addr_byte_ff == cfg.receiver_address);

   // crc step and channel unpacking
   assign crc_next    = rcsfr_pkg::crc8_update(crc_acc_ff, buf_rd_data, poly_ff);
   assign chan_base   = RA_W'(rcsfr_pkg::PAYLOAD_START) + RA_W'(bitpos_ff >> 3);
   assign asm_shifted = asm_ff >> bitpos_ff[2:0];
   assign ch_last     = (ch_ff == IDX_W'(CHANNEL_COUNT - 1));
   assign out_free    = !rsp_valid_ff || rsp.ready;

   // buffer ports
   assign buf_wr_en   = accept && !skip;
   assign buf_wr_addr = pos_eff[AW-1:0];
   assign buf_wr_data = req.byte_value;

   always_comb begin
      buf_rd_en   = 1'b0;
      buf_rd_addr = chan_base;
      unique case (state_ff)
         ST_CRC_RD: begin
            buf_rd_en   = 1'b1;
            buf_rd_addr = RA_W'(rd_addr_ff);
         end
         ST_CH_RD0: begin
            buf_rd_en   = 1'b1;
            buf_rd_addr = chan_base;
         end
         ST_CH_RD1: begin
            buf_rd_en   = 1'b1;
            buf_rd_addr = chan_base + RA_W'(1);
         end
         ST_CH_RD2: begin
            buf_rd_en   = 1'b1;
            buf_rd_addr = chan_base + RA_W'(2);
         end
         default: begin
         end
      endcase
   end

   // control sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         start_ff     <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rdv_ff <= buf_rd_en;
         // a transfer frees the result register; in the emit state the next channel loads it
         if (rsp_valid_ff && rsp.ready && (state_ff != ST_CH_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  pos_ff <= skip ? pos_eff : pos_new;
                  if (pos_eff == '0) begin
                     start_ff <= req.arrival_time_us;
                  end
                  if (!skip) begin
                     if (pos_eff == POS_W'(rcsfr_pkg::POS_ADDR)) begin
                        addr_byte_ff <= req.byte_value;
                     end
                     if (pos_eff == POS_W'(rcsfr_pkg::POS_LEN)) begin
                        len_byte_ff <= req.byte_value;
                     end
                     if (pos_eff == POS_W'(rcsfr_pkg::POS_TYPE)) begin
                        type_byte_ff <= req.byte_value;
                     end
                  end
                  // frame complete: snapshot what the crc pass and decode need
                  if (done) begin
                     last_idx_ff <= AW'(full - FULL_W'(rcsfr_pkg::LEN_OVERHEAD));
                     rd_addr_ff  <= AW'(rcsfr_pkg::POS_TYPE);
                     crc_rx_ff   <= req.byte_value;
                     crc_acc_ff  <= '0;
                     poly_ff     <= cfg.crc_polynomial;
                     rc_ok_ff    <= rc_frame;
                     state_ff    <= ST_CRC_RD;
                  end
               end
            end
            ST_CRC_RD: begin
               if (rdv_ff) begin
                  crc_acc_ff <= crc_next;
               end
               if (rd_addr_ff == last_idx_ff) begin
                  state_ff <= ST_CRC_END;
               end else begin
                  rd_addr_ff <= rd_addr_ff + AW'(1);
               end
            end
            ST_CRC_END: begin
               // mismatch keeps the position at the frame end
               if (crc_next == crc_rx_ff) begin
                  pos_ff <= '0;
                  if (rc_ok_ff) begin
                     ch_ff     <= '0;
                     bitpos_ff <= '0;
                     state_ff  <= ST_CH_RD0;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_CH_RD0: begin
               state_ff <= ST_CH_RD1;
            end
            ST_CH_RD1: begin
               asm_ff   <= {buf_rd_data, asm_ff[ASM_W-1:rcsfr_pkg::BYTE_W]};
               state_ff <= ST_CH_RD2;
            end
            ST_CH_RD2: begin
               asm_ff   <= {buf_rd_data, asm_ff[ASM_W-1:rcsfr_pkg::BYTE_W]};
               state_ff <= ST_CH_CAP;
            end
            ST_CH_CAP: begin
               asm_ff   <= {buf_rd_data, asm_ff[ASM_W-1:rcsfr_pkg::BYTE_W]};
               state_ff <= ST_CH_EMIT;
            end
            ST_CH_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_index_ff <= ch_ff;
                  rsp_value_ff <= asm_shifted[VAL_W-1:0];
                  rsp_last_ff  <= ch_last;
                  ch_ff        <= ch_ff + IDX_W'(1);
                  bitpos_ff    <= bitpos_ff + BP_W'(rcsfr_pkg::CH_BITS);
                  state_ff     <= ch_last ? ST_IDLE : ST_CH_RD0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req.ready         = (state_ff == ST_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.channel_index = rsp_index_ff;
   assign rsp.channel_value = rsp_value_ff;
   assign rsp.last_channel  = rsp_last_ff;

endmodule

@@ rtl/core/rc_serial_frame_receiver.sv @@
// rc_serial_frame_receiver: top level of the serial rc frame receiver
// depends on rcsfr_pkg, rcsfr_req_if, rcsfr_rsp_if, rcsfr_csr, rcsfr_buffer, rcsfr_sequencer
//
//   channel  | dir | transfer                      | payload
//   req_chan | in  | valid & ready                 | byte_value, arrival_time_us
//   rsp_chan | out | valid & ready                 | channel_index, channel_value, last_channel
//   csr_*    | in  | psel & penable & pwrite       | paddr[4:2] register, pwdata
//
// a byte that does not end a frame leaves ready high for the next
// a frame end adds a crc pass over the buffer ram, one byte a cycle
// a matching rc frame then unpacks channels, three ram reads each, then a capture and an emit step
// reset is synchronous; buffer valid bits clear at once, so there is no clearing pass
// a stalled result channel holds channel unpacking; bytes are refused until it ends

module rc_serial_frame_receiver #(
   parameter int MAX_FRAME_BYTES = rcsfr_pkg::DEF_MAX_FRAME_BYTES,
   parameter int CHANNEL_COUNT   = rcsfr_pkg::DEF_CHANNEL_COUNT
) (
   input  logic                              clock,
   input  logic                              reset,
   rcsfr_req_if.sink                         req_chan,
   rcsfr_rsp_if.source                       rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rcsfr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rcsfr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rcsfr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);

   localparam int RA_W = rcsfr_pkg::read_addr_width(MAX_FRAME_BYTES, CHANNEL_COUNT);
   localparam int AW   = $clog2(MAX_FRAME_BYTES);

   rcsfr_pkg::cfg_type            cfg;
   logic                          buf_wr_en;
   logic [AW-1:0]                 buf_wr_addr;
   logic [rcsfr_pkg::BYTE_W-1:0]  buf_wr_data;
   logic                          buf_rd_en;
   logic [RA_W-1:0]               buf_rd_addr;
   logic [rcsfr_pkg::BYTE_W-1:0]  buf_rd_data;

   // configuration registers
   rcsfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // frame byte store
   rcsfr_buffer #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
      .RA_W            (RA_W)
   ) u_buffer (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (buf_wr_en),
      .wr_addr (buf_wr_addr),
      .wr_data (buf_wr_data),
      .rd_en   (buf_rd_en),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data)
   );

   // framing, crc and channel unpacking
   rcsfr_sequencer #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
      .CHANNEL_COUNT   (CHANNEL_COUNT),
      .RA_W            (RA_W)
   ) u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .buf_wr_en   (buf_wr_en),
      .buf_wr_addr (buf_wr_addr),
      .buf_wr_data (buf_wr_data),
      .buf_rd_en   (buf_rd_en),
      .buf_rd_addr (buf_rd_addr),
      .buf_rd_data (buf_rd_data)
   );

`ifndef SYNTHESIS
   // the last flag marks exactly the final channel index
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.last_channel ==
         (rsp_chan.channel_index == rcsfr_pkg::CH_INDEX_W'(CHANNEL_COUNT - 1))))
      else $error("last_channel does not match the final channel index");

   // while a frame's channels are still going out no byte is taken
   a_busy_in_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_channel) |-> !req_chan.ready)
      else $error("byte channel ready in the middle of a channel burst");

   // the buffer is written only by an accepted byte
   a_write_on_transfer: assert property (@(posedge clock) disable iff (reset)
      buf_wr_en |-> (req_chan.valid && req_chan.ready))
      else $error("frame buffer written without a byte transfer");
`endif

endmodule
